FILE: hw/rtl/mwba_pkg.sv
// ----------------------------------------------------------------------------
// mwba_pkg: shared definitions for the masked weighted band average
// Register index codes, fixed field widths and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mwba_pkg;

  // Fixed widths of the configuration registers and of the result.
  localparam int WEIGHT_W    = 16;
  localparam int NULL_W      = 16;
  localparam int AVG_W       = 16;
  localparam int COUNT_W     = 2;
  localparam int BAND_IDX_W  = 2;
  localparam int NUM_BAND_REGS = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 2'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT0    = 3'd0,
    REG_WEIGHT1    = 3'd1,
    REG_WEIGHT2    = 3'd2,
    REG_NULL0      = 3'd3,
    REG_NULL1      = 3'd4,
    REG_NULL2      = 3'd5,
    REG_OUTPUT_NULL = 3'd6,
    REG_BAND_COUNT = 3'd7
  } cfg_reg_e;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mwba_div.sv
// ----------------------------------------------------------------------------
// mwba_div: iterative restoring divider
// Produces one quotient bit per cycle; the quotient must fit in QUOT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mwba_div #(
  parameter int QUOT_W    = 16,
  parameter int DIVISOR_W = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [DIVISOR_W+QUOT_W-1:0]   dividend_i,
  input  wire logic [DIVISOR_W-1:0]          divisor_i,
  output logic      [QUOT_W-1:0]             quotient_o,
  output mwba_pkg::div_status_t              status_o
);

  localparam int DIVIDEND_W = DIVISOR_W + QUOT_W;
  localparam int CNT_W      = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [QUOT_W-1:0]    quo_q;
  logic [DIVISOR_W-1:0] divisor_q;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 qbit;

  // The partial remainder stays below the divisor, so the shifted trial
  // value needs only one extra bit.
  assign trial = {rem_q, quo_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign qbit  = ~diff[DIVISOR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(QUOT_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= dividend_i[DIVIDEND_W-1:QUOT_W];
      quo_q     <= dividend_i[QUOT_W-1:0];
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[QUOT_W-2:0], qbit};
    end
  end

  assign quotient_o     = quo_q;
  assign status_o.busy  = (cnt_q != '0);
  assign status_o.done  = done_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (cnt_q == '0))
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q == CNT_W'(1)))
    else $error("divider done without a final step");
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_q == '0))
    else $error("divider done while still busy");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/masked_weighted_band_average.sv
// ----------------------------------------------------------------------------
// masked_weighted_band_average: weighted band average with null masking
// Accumulates weighted band samples of a pixel and divides by the weight sum.
// ----------------------------------------------------------------------------
// Band samples of a pixel enter one transaction at a time, in band order.
// A sample equal to its band's null value is skipped; every other sample adds
// weight * sample and the weight to two running sums. The last band of the
// pixel produces one result transaction: the truncated quotient of the two
// sums with any_valid set, or the output null value with any_valid clear when
// no band carried weight. A band count of 1 passes each sample straight
// through, and any_valid then flags a sample that differs from band 0's null.
// Timing: the block takes one sample at a time. A sample that does not end a
// pixel passes through the accept, multiply and accumulate steps. The last
// sample of a pixel with a nonzero weight sum also runs the shared restoring
// divider, one quotient bit per cycle, before its result step; a pass-through
// sample goes from accept straight to the result step. A finished result sits
// in the output register, so the next pixel can start while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_weighted_band_average #(
  parameter int MAX_BANDS   = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [mwba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mwba_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Sample input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [15:0]                       sample_i,
  // Result output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [mwba_pkg::AVG_W-1:0]        average_o,
  output logic                                   any_valid_o
);

  // Weight sum grows by the band count; the weighted sum also carries the
  // sample width. Since the average never exceeds the largest sample, the
  // quotient fits in SAMPLE_BITS.
  localparam int WTS_W  = mwba_pkg::WEIGHT_W + $clog2(MAX_BANDS);
  localparam int PROD_W = mwba_pkg::WEIGHT_W + SAMPLE_BITS;
  localparam int WSUM_W = WTS_W + SAMPLE_BITS;
  localparam logic [mwba_pkg::BAND_IDX_W-1:0] MAX_BANDS_L =
    mwba_pkg::BAND_IDX_W'(MAX_BANDS);
  localparam logic [mwba_pkg::COUNT_W-1:0] MAX_COUNT_L =
    mwba_pkg::COUNT_W'(MAX_BANDS);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_RES  = 5'b10000
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mwba_pkg::WEIGHT_W-1:0] weight_q [mwba_pkg::NUM_BAND_REGS];
  logic [mwba_pkg::NULL_W-1:0]   null_q   [mwba_pkg::NUM_BAND_REGS];
  logic [mwba_pkg::NULL_W-1:0]   out_null_q;
  logic [mwba_pkg::COUNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mwba_pkg::NUM_BAND_REGS; i++) begin
        weight_q[i] <= mwba_pkg::WEIGHT_RESET;
        null_q[i]   <= '0;
      end
      out_null_q <= '0;
      count_q    <= mwba_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (mwba_pkg::cfg_reg_e'(cfg_index_i))
        mwba_pkg::REG_WEIGHT0:     weight_q[0] <= cfg_data_i;
        mwba_pkg::REG_WEIGHT1:     weight_q[1] <= cfg_data_i;
        mwba_pkg::REG_WEIGHT2:     weight_q[2] <= cfg_data_i;
        mwba_pkg::REG_NULL0:       null_q[0]   <= cfg_data_i;
        mwba_pkg::REG_NULL1:       null_q[1]   <= cfg_data_i;
        mwba_pkg::REG_NULL2:       null_q[2]   <= cfg_data_i;
        mwba_pkg::REG_OUTPUT_NULL: out_null_q  <= cfg_data_i;
        mwba_pkg::REG_BAND_COUNT:  count_q     <= cfg_data_i[mwba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Decode of the incoming sample
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [mwba_pkg::BAND_IDX_W-1:0] pos_q;
  logic [SAMPLE_BITS-1:0]          s_in;
  logic [mwba_pkg::COUNT_W-1:0]    n_eff;
  logic                            pos_ok;
  logic [mwba_pkg::BAND_IDX_W-1:0] pos_sel;
  logic                            band_hit;
  logic                            last_in;
  logic                            pass_in;
  logic                            accept_in;

  assign s_in      = sample_i[SAMPLE_BITS-1:0];
  assign accept_in = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // A count of zero behaves as one; a count beyond the built bands saturates.
  always_comb begin
    n_eff = count_q;
    if (count_q == '0) begin
      n_eff = mwba_pkg::COUNT_W'(1);
    end else if (count_q > MAX_COUNT_L) begin
      n_eff = MAX_COUNT_L;
    end
  end

  assign pass_in  = (n_eff == mwba_pkg::COUNT_W'(1));
  assign pos_ok   = (pos_q < MAX_BANDS_L);
  assign pos_sel  = pos_ok ? pos_q : '0;
  assign band_hit = pos_ok && (s_in != null_q[pos_sel][SAMPLE_BITS-1:0]);
  // The pixel ends on the configured last band, or on a position that has no
  // band behind it.
  assign last_in  = (({1'b0, pos_q} + 3'd1) >= {1'b0, n_eff}) || !pos_ok;

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0]        sample_q;
  logic [mwba_pkg::WEIGHT_W-1:0] wgt_q;
  logic                          use_q;
  logic                          last_q;
  logic [PROD_W-1:0]             prod_q;
  logic [WSUM_W-1:0]             wsum_q;
  logic [WTS_W-1:0]              wts_q;
  logic [WSUM_W-1:0]             wsum_d;
  logic [WTS_W-1:0]              wts_d;
  logic [mwba_pkg::AVG_W-1:0]    res_avg_q;
  logic                          res_any_q;
  logic                          out_valid_q;
  logic [mwba_pkg::AVG_W-1:0]    out_avg_q;
  logic                          out_any_q;
  logic                          out_free;

  logic                          div_start;
  logic [SAMPLE_BITS-1:0]        div_quot;
  mwba_pkg::div_status_t         div_status;

  assign wsum_d = wsum_q + (use_q ? WSUM_W'(prod_q) : '0);
  assign wts_d  = wts_q + (use_q ? WTS_W'(wgt_q) : '0);

  assign out_free  = !out_valid_q || out_ready_i;
  assign div_start = (state_q == S_ACC) && last_q && (wts_d != '0);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          state_d = pass_in ? S_RES : S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (wts_d != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_RES;
        end
      end
      S_DIV: begin
        if (div_status.done) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      wsum_q      <= '0;
      wts_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Pass-through clears the pixel; the end of a pixel clears it too.
      if (accept_in && pass_in) begin
        pos_q  <= '0;
        wsum_q <= '0;
        wts_q  <= '0;
      end else if (state_q == S_ACC) begin
        if (last_q) begin
          pos_q  <= '0;
          wsum_q <= '0;
          wts_q  <= '0;
        end else begin
          pos_q  <= pos_q + 1'b1;
          wsum_q <= wsum_d;
          wts_q  <= wts_d;
        end
      end

      if ((state_q == S_RES) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      sample_q <= s_in;
      wgt_q    <= weight_q[pos_sel];
      use_q    <= band_hit;
      last_q   <= last_in;
      if (pass_in) begin
        res_avg_q <= mwba_pkg::AVG_W'(s_in);
        res_any_q <= (s_in != null_q[0][SAMPLE_BITS-1:0]);
      end
    end

    // The multiplier is the one product unit; its result is registered
    // before the accumulate step.
    if (state_q == S_MUL) begin
      prod_q <= wgt_q * sample_q;
    end

    if ((state_q == S_ACC) && last_q && (wts_d == '0)) begin
      res_avg_q <= out_null_q;
      res_any_q <= 1'b0;
    end

    if ((state_q == S_DIV) && div_status.done) begin
      res_avg_q <= mwba_pkg::AVG_W'(div_quot);
      res_any_q <= 1'b1;
    end

    if ((state_q == S_RES) && out_free) begin
      out_avg_q <= res_avg_q;
      out_any_q <= res_any_q;
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider: weighted sum over weight sum, one quotient bit per cycle
  // --------------------------------------------------------------------------
  mwba_div #(
    .QUOT_W    (SAMPLE_BITS),
    .DIVISOR_W (WTS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wsum_d),
    .divisor_i  (wts_d),
    .quotient_o (div_quot),
    .status_o   (div_status)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign any_valid_o = out_any_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> !in_ready_o)
    else $error("new sample taken while the previous one is in flight");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < MAX_BANDS_L)
    else $error("band position beyond the built bands");
  a_div_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_status.busy || div_status.done))
    else $error("waiting on an idle divider");
`endif

endmodule

`default_nettype wire
